@@ src/acsf_pkg.sv @@
// Shared types, constants and helper functions of the accelerometer calibration filter.
`default_nettype none

package acsf_pkg;

    localparam int NLanes  = 3;
    localparam int WordW   = 16;
    localparam int DataW   = 32;
    localparam int SensW   = 16;
    localparam int WgtW    = 17;
    localparam int ThrW    = 32;
    localparam int NeedW   = 10;
    localparam int TrialW  = 16;
    localparam int SumW    = 42;
    localparam int SqW     = 48;
    localparam int DistW   = 50;
    localparam int PhaseW  = 2;
    localparam int WideW   = 51;
    localparam int DivCntW = $clog2(SumW);

    localparam int InDataW  = 48;
    localparam int OutDataW = 200;
    localparam int AddrW    = 5;
    localparam int ApbW     = 32;

    localparam logic [WgtW-1:0]   WgtOne        = WgtW'(65536);
    localparam logic [SensW-1:0]  SensReset     = SensW'(256);
    localparam logic [WgtW-1:0]   WgtReset      = WgtW'(65536);
    localparam logic [ThrW-1:0]   ThrReset      = ThrW'(164);
    localparam logic [NeedW-1:0]  NeedReset     = NeedW'(100);
    localparam logic [TrialW-1:0] TrialReset    = TrialW'(1000);
    localparam logic [NeedW-1:0]  NeedMax       = '1;
    localparam logic [TrialW-1:0] TrialMax      = '1;

    localparam logic signed [WideW-1:0] Max32 = WideW'(64'sd2147483647);
    localparam logic signed [WideW-1:0] Min32 = WideW'(-64'sd2147483648);

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SENS  = 3'd0;
    localparam logic [2:0] REG_WGT   = 3'd1;
    localparam logic [2:0] REG_THR   = 3'd2;
    localparam logic [2:0] REG_NEED  = 3'd3;
    localparam logic [2:0] REG_TRIAL = 3'd4;

    typedef enum logic [PhaseW-1:0] {
        PH_NEVER = 2'd0,
        PH_RUN   = 2'd1,
        PH_DONE  = 2'd2,
        PH_FAIL  = 2'd3
    } t_phase;

    typedef struct packed {
        logic load;
        logic scale;
        logic acc;
        logic mul;
        logic sq;
        logic commit;
        logic take_last;
    } t_lane_ctl;

    typedef struct packed {
        logic start;
        logic measure;
        logic decide;
    } t_merge_ctl;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] v);
        logic signed [DataW-1:0] r;
        if (v > Max32) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < Min32) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[DataW-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/acsf_lane.sv @@
// One axis lane: negation, scaling, offset removal, low-pass filter and squared distance.
`default_nettype none

module acsf_lane (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire acsf_pkg::t_lane_ctl                i_ctl,
    input  wire logic signed [acsf_pkg::WordW-1:0]  i_word,
    input  wire logic [acsf_pkg::SensW-1:0]         i_sens,
    input  wire logic [acsf_pkg::WgtW-1:0]          i_wgt,
    input  wire logic signed [acsf_pkg::DataW-1:0]  i_off,
    output logic signed [acsf_pkg::DataW-1:0]       o_acc,
    output logic signed [acsf_pkg::DataW-1:0]       o_smooth,
    output logic [acsf_pkg::SqW-1:0]                o_sq
);

    logic signed [acsf_pkg::WordW-1:0] r_raw;
    logic signed [acsf_pkg::DataW-1:0] r_prod;
    logic signed [acsf_pkg::DataW-1:0] r_acc;
    logic signed [48:0]                r_p_old;
    logic signed [48:0]                r_p_new;
    logic [acsf_pkg::DataW-1:0]        r_mag;
    logic [acsf_pkg::SqW-1:0]          r_sq;
    logic signed [acsf_pkg::DataW-1:0] r_blend;
    logic signed [acsf_pkg::DataW-1:0] r_smooth;
    logic signed [acsf_pkg::DataW-1:0] r_last;

    logic signed [32:0]                   w_prod;
    logic signed [32:0]                   w_diff;
    logic [acsf_pkg::WgtW-1:0]            w_inv;
    logic signed [48:0]                   w_p_old;
    logic signed [48:0]                   w_p_new;
    logic signed [32:0]                   w_dist;
    logic [32:0]                          w_dabs;
    logic [63:0]                          w_sqf;
    logic signed [acsf_pkg::WideW-1:0]    w_bsum;
    logic signed [acsf_pkg::WideW-1:0]    w_bsh;

    always_comb begin
        w_prod  = $signed({{17{r_raw[15]}}, r_raw}) * $signed({17'b0, i_sens});
        w_diff  = $signed({r_prod[31], r_prod}) - $signed({i_off[31], i_off});
        w_inv   = acsf_pkg::WgtOne - i_wgt;
        w_p_old = $signed({{17{r_smooth[31]}}, r_smooth}) * $signed({32'b0, w_inv});
        w_p_new = $signed({{17{r_acc[31]}}, r_acc}) * $signed({32'b0, i_wgt});
        w_dist  = $signed({r_last[31], r_last}) - $signed({r_acc[31], r_acc});
        w_dabs  = w_dist[32] ? 33'(-w_dist) : 33'(w_dist);
        w_sqf   = {32'b0, r_mag} * {32'b0, r_mag};
        // Rounding constant added before the floor shift.
        w_bsum  = $signed({{2{r_p_old[48]}}, r_p_old}) + $signed({{2{r_p_new[48]}}, r_p_new})
                + acsf_pkg::WideW'(32768);
        w_bsh   = w_bsum >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_raw <= (i_word == 16'sh8000) ? 16'sh7FFF : -i_word;
        end
        if (i_ctl.scale) begin
            r_prod <= w_prod[acsf_pkg::DataW-1:0];
        end
        if (i_ctl.acc) begin
            r_acc <= acsf_pkg::sat32(acsf_pkg::WideW'(w_diff));
        end
        if (i_ctl.mul) begin
            r_p_old <= w_p_old;
            r_p_new <= w_p_new;
            r_mag   <= w_dabs[acsf_pkg::DataW-1:0];
        end
        if (i_ctl.sq) begin
            r_sq    <= w_sqf[63:16];
            r_blend <= acsf_pkg::sat32(w_bsh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= '0;
            r_last   <= '0;
        end else begin
            if (i_ctl.commit) begin
                r_smooth <= r_blend;
            end
            if (i_ctl.take_last) begin
                r_last <= r_acc;
            end
        end
    end

    assign o_acc    = r_acc;
    assign o_smooth = r_smooth;
    assign o_sq     = r_sq;

endmodule

`default_nettype wire

@@ src/acsf_div.sv @@
// Restoring divider, one quotient bit per cycle, for the offset averages.
`default_nettype none

module acsf_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [acsf_pkg::SumW-1:0]    i_dividend,
    input  wire logic [acsf_pkg::NeedW-1:0]   i_divisor,
    output logic                              o_busy,
    output logic [acsf_pkg::SumW-1:0]         o_quot
);

    logic                           r_busy;
    logic [acsf_pkg::DivCntW-1:0]   r_cnt;
    logic [acsf_pkg::SumW-1:0]      r_quot;
    logic [acsf_pkg::NeedW-1:0]     r_rem;
    logic [acsf_pkg::NeedW-1:0]     r_dsr;

    logic [acsf_pkg::NeedW:0]       w_trial;
    logic                           w_ge;

    always_comb begin
        w_trial = {r_rem, r_quot[acsf_pkg::SumW-1]};
        w_ge    = w_trial >= {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == acsf_pkg::DivCntW'(acsf_pkg::SumW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dsr  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[acsf_pkg::SumW-2:0], w_ge};
            r_rem  <= w_ge ? acsf_pkg::NeedW'(w_trial - {1'b0, r_dsr})
                           : w_trial[acsf_pkg::NeedW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ src/acsf_merge.sv @@
// Merging stage: sums the lane distances and runs the calibration bookkeeping.
`default_nettype none

module acsf_merge (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire acsf_pkg::t_merge_ctl                          i_ctl,
    input  wire logic signed [acsf_pkg::DataW-1:0]             i_acc0,
    input  wire logic signed [acsf_pkg::DataW-1:0]             i_acc1,
    input  wire logic [acsf_pkg::NLanes-1:0][acsf_pkg::SqW-1:0] i_sq,
    input  wire logic [acsf_pkg::ThrW-1:0]                     i_thr,
    input  wire logic [acsf_pkg::NeedW-1:0]                    i_need,
    input  wire logic [acsf_pkg::TrialW-1:0]                   i_trial_lim,
    output logic signed [acsf_pkg::DataW-1:0]                  o_off0,
    output logic signed [acsf_pkg::DataW-1:0]                  o_off1,
    output acsf_pkg::t_phase                                   o_phase,
    output logic                                               o_take_last,
    output logic                                               o_busy
);

    logic signed [acsf_pkg::DataW-1:0] r_off0;
    logic signed [acsf_pkg::DataW-1:0] r_off1;
    logic signed [acsf_pkg::SumW-1:0]  r_sum0;
    logic signed [acsf_pkg::SumW-1:0]  r_sum1;
    logic [acsf_pkg::NeedW-1:0]        r_count;
    logic [acsf_pkg::TrialW-1:0]       r_trial;
    acsf_pkg::t_phase                  r_phase;
    logic                              r_need_ref;
    logic                              r_stable;
    logic                              r_div_go;
    logic                              r_div_run;

    logic [acsf_pkg::DistW-1:0]        w_dist;
    logic [acsf_pkg::NeedW-1:0]        w_needed;
    logic [acsf_pkg::NeedW-1:0]        w_count;
    logic [acsf_pkg::TrialW-1:0]       w_trial;
    logic                              w_running;
    logic [acsf_pkg::SumW-1:0]         w_dvd0;
    logic [acsf_pkg::SumW-1:0]         w_dvd1;
    logic [acsf_pkg::SumW-1:0]         w_q0;
    logic [acsf_pkg::SumW-1:0]         w_q1;
    logic                              w_busy0;
    logic                              w_busy1;
    logic                              w_div_end;

    function automatic logic signed [acsf_pkg::DataW-1:0] fix_sign(
        input logic                        neg,
        input logic [acsf_pkg::SumW-1:0]   q
    );
        logic big;
        logic signed [acsf_pkg::DataW-1:0] r;
        big = |q[acsf_pkg::SumW-1:acsf_pkg::DataW-1];
        if (neg) begin
            // A magnitude of exactly 2^31 still maps to the most negative value.
            r = (q > acsf_pkg::SumW'(64'h8000_0000)) ? 32'sh8000_0000
                                                     : -$signed(q[acsf_pkg::DataW-1:0]);
        end else begin
            r = big ? 32'sh7FFF_FFFF : $signed(q[acsf_pkg::DataW-1:0]);
        end
        return r;
    endfunction

    always_comb begin
        w_dist = acsf_pkg::DistW'(i_sq[0]) + acsf_pkg::DistW'(i_sq[1])
               + acsf_pkg::DistW'(i_sq[2]);
        w_needed  = (i_need == '0) ? acsf_pkg::NeedW'(1) : i_need;
        w_running = (r_phase == acsf_pkg::PH_RUN) && !r_need_ref;
        w_trial   = (r_trial == acsf_pkg::TrialMax) ? r_trial : r_trial + 1'b1;
        w_count   = (r_stable && r_count != acsf_pkg::NeedMax) ? r_count + 1'b1 : r_count;
        w_dvd0    = (r_sum0[acsf_pkg::SumW-1] ? acsf_pkg::SumW'(-r_sum0)
                                              : acsf_pkg::SumW'(r_sum0))
                  + acsf_pkg::SumW'(r_count[acsf_pkg::NeedW-1:1]);
        w_dvd1    = (r_sum1[acsf_pkg::SumW-1] ? acsf_pkg::SumW'(-r_sum1)
                                              : acsf_pkg::SumW'(r_sum1))
                  + acsf_pkg::SumW'(r_count[acsf_pkg::NeedW-1:1]);
        w_div_end = r_div_run && !r_div_go && !w_busy0 && !w_busy1;
    end

    acsf_div u_div0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (w_dvd0),
        .i_divisor  (r_count),
        .o_busy     (w_busy0),
        .o_quot     (w_q0)
    );

    acsf_div u_div1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (w_dvd1),
        .i_divisor  (r_count),
        .o_busy     (w_busy1),
        .o_quot     (w_q1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off0     <= '0;
            r_off1     <= '0;
            r_sum0     <= '0;
            r_sum1     <= '0;
            r_count    <= '0;
            r_trial    <= '0;
            r_phase    <= acsf_pkg::PH_NEVER;
            r_need_ref <= 1'b0;
            r_stable   <= 1'b0;
            r_div_go   <= 1'b0;
            r_div_run  <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (i_ctl.measure) begin
                r_stable <= w_dist < acsf_pkg::DistW'(i_thr);
            end
            if (i_ctl.start) begin
                r_off0     <= '0;
                r_off1     <= '0;
                r_sum0     <= '0;
                r_sum1     <= '0;
                r_count    <= '0;
                r_trial    <= '0;
                r_phase    <= acsf_pkg::PH_RUN;
                r_need_ref <= 1'b1;
                r_div_run  <= 1'b0;
            end else if (i_ctl.decide && r_phase == acsf_pkg::PH_RUN) begin
                if (r_need_ref) begin
                    r_need_ref <= 1'b0;
                end else begin
                    r_trial <= w_trial;
                    r_count <= w_count;
                    if (r_stable) begin
                        r_sum0 <= r_sum0 + acsf_pkg::SumW'(i_acc0);
                        r_sum1 <= r_sum1 + acsf_pkg::SumW'(i_acc1);
                    end
                    if (w_count >= w_needed) begin
                        r_phase  <= acsf_pkg::PH_DONE;
                        r_div_go <= 1'b1;
                    end else if (w_trial >= i_trial_lim) begin
                        r_off0  <= '0;
                        r_off1  <= '0;
                        r_phase <= acsf_pkg::PH_FAIL;
                    end
                end
            end else if (r_div_go) begin
                r_div_run <= 1'b1;
            end else if (w_div_end) begin
                r_div_run <= 1'b0;
                r_off0    <= fix_sign(r_sum0[acsf_pkg::SumW-1], w_q0);
                r_off1    <= fix_sign(r_sum1[acsf_pkg::SumW-1], w_q1);
            end
        end
    end

    assign o_off0      = r_off0;
    assign o_off1      = r_off1;
    assign o_phase     = r_phase;
    assign o_take_last = i_ctl.decide && (r_phase == acsf_pkg::PH_RUN)
                       && (r_need_ref || (w_running && r_stable));
    assign o_busy      = r_div_go || r_div_run;

    a_div_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_run |-> r_phase == acsf_pkg::PH_DONE)
        else $error("offset division running outside the finished phase");

    a_trial_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_ctl.decide && !i_ctl.start) |=> $stable(r_trial))
        else $error("trial count moved without a calibration step");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |=> (r_phase == acsf_pkg::PH_RUN && r_trial == '0 && r_count == '0))
        else $error("start command did not restart calibration");

endmodule

`default_nettype wire

@@ src/accel_sample_calib_filter_core.sv @@
// Top level: stream ports, configuration registers, sequencer and output register.
//
//  Channel   Direction  Handshake                  Payload
//  s_axis    in         i_s_axis_tvalid/o_..tready tdata: word_first, word_second, word_third
//                                                  tuser: command
//  m_axis    out        o_m_axis_tvalid/i_..tready tdata: accel_axis0..2, smooth_axis0..2,
//                                                  calib_phase
//  apb       in         psel/penable/pwrite/pready five registers at byte address 4*index
//
// A sensor sample runs through the scale, offset, multiply, square, distance and update steps
// of the three lanes, then the division and output steps, before the next input is taken. A
// start command goes straight to the output step. A sample that completes calibration waits in
// the 42-step offset division. Synchronous reset clears all but the datapath registers.
// A stalled output keeps its result in the output register; a further item may be taken
// and is held in its last step until the register frees up.
`default_nettype none

module accel_sample_calib_filter_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata: word_first [15:0], word_second [31:16], word_third [47:32]
    input  wire logic [acsf_pkg::InDataW-1:0]      i_s_axis_tdata,
    // tuser: command [0]
    input  wire logic                              i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // tdata: accel_axis0..2 [95:0], smooth_axis0..2 [191:96], calib_phase [193:192], zeros
    output logic [acsf_pkg::OutDataW-1:0]          o_m_axis_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [acsf_pkg::AddrW-1:0]        paddr,
    input  wire logic [acsf_pkg::ApbW-1:0]         pwdata,
    output logic [acsf_pkg::ApbW-1:0]              prdata,
    output logic                                   pready
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCALE  = 9'b000000010,
        S_ACC    = 9'b000000100,
        S_MUL    = 9'b000001000,
        S_SQ     = 9'b000010000,
        S_DIST   = 9'b000100000,
        S_DECIDE = 9'b001000000,
        S_DIV    = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state                            r_state;
    t_state                            n_state;
    logic                              r_cmd;
    logic [acsf_pkg::SensW-1:0]        r_sens;
    logic [acsf_pkg::WgtW-1:0]         r_wgt;
    logic [acsf_pkg::ThrW-1:0]         r_thr;
    logic [acsf_pkg::NeedW-1:0]        r_need;
    logic [acsf_pkg::TrialW-1:0]       r_trial_lim;
    logic                              r_m_valid;
    logic [acsf_pkg::OutDataW-1:0]     r_m_data;

    logic                                                 w_in_xfer;
    logic                                                 w_cfg_wr;
    logic                                                 w_out_load;
    logic [acsf_pkg::WgtW-1:0]                            w_wgt;
    acsf_pkg::t_lane_ctl                                  w_lane_ctl;
    acsf_pkg::t_merge_ctl                                 w_merge_ctl;
    logic signed [acsf_pkg::WordW-1:0]                    w_word [acsf_pkg::NLanes];
    logic signed [acsf_pkg::DataW-1:0]                    w_off  [acsf_pkg::NLanes];
    logic signed [acsf_pkg::DataW-1:0]                    w_acc  [acsf_pkg::NLanes];
    logic signed [acsf_pkg::DataW-1:0]                    w_smth [acsf_pkg::NLanes];
    logic [acsf_pkg::NLanes-1:0][acsf_pkg::SqW-1:0]       w_sq;
    logic signed [acsf_pkg::DataW-1:0]                    w_off0;
    logic signed [acsf_pkg::DataW-1:0]                    w_off1;
    acsf_pkg::t_phase                                     w_phase;
    logic                                                 w_take_last;
    logic                                                 w_busy;
    logic [acsf_pkg::DataW*acsf_pkg::NLanes-1:0]          w_acc_out;
    logic [acsf_pkg::OutDataW-1:0]                        w_result;

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign w_out_load = (r_state == S_OUT) && (!r_m_valid || i_m_axis_tready);
    assign w_wgt      = (r_wgt > acsf_pkg::WgtOne) ? acsf_pkg::WgtOne : r_wgt;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens      <= acsf_pkg::SensReset;
            r_wgt       <= acsf_pkg::WgtReset;
            r_thr       <= acsf_pkg::ThrReset;
            r_need      <= acsf_pkg::NeedReset;
            r_trial_lim <= acsf_pkg::TrialReset;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                acsf_pkg::REG_SENS:  r_sens      <= pwdata[acsf_pkg::SensW-1:0];
                acsf_pkg::REG_WGT:   r_wgt       <= pwdata[acsf_pkg::WgtW-1:0];
                acsf_pkg::REG_THR:   r_thr       <= pwdata[acsf_pkg::ThrW-1:0];
                acsf_pkg::REG_NEED:  r_need      <= pwdata[acsf_pkg::NeedW-1:0];
                acsf_pkg::REG_TRIAL: r_trial_lim <= pwdata[acsf_pkg::TrialW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            acsf_pkg::REG_SENS:  prdata = acsf_pkg::ApbW'(r_sens);
            acsf_pkg::REG_WGT:   prdata = acsf_pkg::ApbW'(r_wgt);
            acsf_pkg::REG_THR:   prdata = r_thr;
            acsf_pkg::REG_NEED:  prdata = acsf_pkg::ApbW'(r_need);
            acsf_pkg::REG_TRIAL: prdata = acsf_pkg::ApbW'(r_trial_lim);
            default:             prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = i_s_axis_tuser ? S_OUT : S_SCALE;
                end
            end
            S_SCALE:  n_state = S_ACC;
            S_ACC:    n_state = S_MUL;
            S_MUL:    n_state = S_SQ;
            S_SQ:     n_state = S_DIST;
            S_DIST:   n_state = S_DECIDE;
            S_DECIDE: n_state = S_DIV;
            S_DIV: begin
                if (!w_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer) begin
                r_cmd <= i_s_axis_tuser;
            end
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        w_lane_ctl.load      = w_in_xfer;
        w_lane_ctl.scale     = (r_state == S_SCALE);
        w_lane_ctl.acc       = (r_state == S_ACC);
        w_lane_ctl.mul       = (r_state == S_MUL);
        w_lane_ctl.sq        = (r_state == S_SQ);
        w_lane_ctl.commit    = (r_state == S_DECIDE);
        w_lane_ctl.take_last = w_take_last;
        w_merge_ctl.start    = w_in_xfer && i_s_axis_tuser;
        w_merge_ctl.measure  = (r_state == S_DIST);
        w_merge_ctl.decide   = (r_state == S_DECIDE);
    end

    // Axis 0 comes from the second word and axis 1 from the first.
    assign w_word[0] = $signed(i_s_axis_tdata[31:16]);
    assign w_word[1] = $signed(i_s_axis_tdata[15:0]);
    assign w_word[2] = $signed(i_s_axis_tdata[47:32]);
    assign w_off[0]  = w_off0;
    assign w_off[1]  = w_off1;
    assign w_off[2]  = '0;

    for (genvar g = 0; g < acsf_pkg::NLanes; g++) begin : g_lane
        acsf_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_lane_ctl),
            .i_word   (w_word[g]),
            .i_sens   (r_sens),
            .i_wgt    (w_wgt),
            .i_off    (w_off[g]),
            .o_acc    (w_acc[g]),
            .o_smooth (w_smth[g]),
            .o_sq     (w_sq[g])
        );
    end

    acsf_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_merge_ctl),
        .i_acc0      (w_acc[0]),
        .i_acc1      (w_acc[1]),
        .i_sq        (w_sq),
        .i_thr       (r_thr),
        .i_need      (r_need),
        .i_trial_lim (r_trial_lim),
        .o_off0      (w_off0),
        .o_off1      (w_off1),
        .o_phase     (w_phase),
        .o_take_last (w_take_last),
        .o_busy      (w_busy)
    );

    // A start command reports zero acceleration.
    assign w_acc_out = r_cmd ? '0 : {w_acc[2], w_acc[1], w_acc[0]};
    assign w_result  = {6'b0, w_phase, w_smth[2], w_smth[1], w_smth[0], w_acc_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_state != S_IDLE)
        else $error("input transfer did not start an item");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result appeared outside the output step");

    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_busy)
        else $error("offset division still running while idle");

endmodule

`default_nettype wire

@@ bench/accel_sample_calib_filter_core_tb.sv @@
// Self-checking testbench for the accelerometer calibration and low-pass filter core.
module accel_sample_calib_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_START  = 1'b1;
    localparam int   IDLE_LIMIT = 20000;
    localparam int   SETTLE     = 64;
    localparam int   PHASE_ITEMS = 210;

    localparam int MODE_NONE = 0;
    localparam int MODE_SRC  = 1;
    localparam int MODE_SINK = 2;
    localparam int MODE_BOTH = 3;

    localparam int PRESS_NONE  = 0;
    localparam int PRESS_STALL = 1;
    localparam int PRESS_PAUSE = 2;

    typedef struct packed {
        logic        cmd;
        logic [15:0] w3;
        logic [15:0] w2;
        logic [15:0] w1;
    } t_sample_in;

    typedef struct packed {
        acsf_pkg::t_phase phase;
        logic [2:0][31:0] smooth;
        logic [2:0][31:0] accel;
    } t_accel_out;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    // tdata: word_first [15:0], word_second [31:16], word_third [47:32]
    logic [acsf_pkg::InDataW-1:0]   i_s_axis_tdata = '0;
    // tuser: command [0]
    logic                           i_s_axis_tuser = 1'b0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    // tdata: accel_axis0..2 [95:0], smooth_axis0..2 [191:96], calib_phase [193:192]
    logic [acsf_pkg::OutDataW-1:0]  o_m_axis_tdata;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [acsf_pkg::AddrW-1:0]     paddr = '0;
    logic [acsf_pkg::ApbW-1:0]      pwdata = '0;
    logic [acsf_pkg::ApbW-1:0]      prdata;
    logic                           pready;

    accel_sample_calib_filter_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    t_sample_in pending_samples[$];
    t_accel_out accel_out_q[$];
    int         mismatches = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    logic       src_hold = 1'b0;
    logic       sink_hold = 1'b0;
    logic       stall_request = 1'b0;

    // Register mirror.
    int unsigned cfg_sens, cfg_wgt, cfg_thr, cfg_need, cfg_trial;

    // Mirror of the block state.
    int               off_x, off_y;
    int               smooth_v [3];
    int               last_v [3];
    longint           stable_total [2];
    int unsigned      stable_n, trial_n;
    acsf_pkg::t_phase cal_phase;
    logic             want_reference;

    // Random calibration scene: a resting position with some jitter around it.
    int          scene_base [3];
    int          scene_jit;

    initial begin
        cfg_sens = 256;
        cfg_wgt = 65536;
        cfg_thr = 164;
        cfg_need = 100;
        cfg_trial = 1000;
        off_x = 0;
        off_y = 0;
        smooth_v = '{0, 0, 0};
        last_v = '{0, 0, 0};
        stable_total = '{0, 0};
        stable_n = 0;
        trial_n = 0;
        cal_phase = acsf_pkg::PH_NEVER;
        want_reference = 1'b0;
        scene_base = '{0, 0, 0};
        scene_jit = 0;
    end

    function automatic int clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic int flip16(input logic signed [15:0] v);
        return (v == -16'sd32768) ? 32767 : -int'(v);
    endfunction

    function automatic int blend(input int prev, input int cur, input int unsigned w);
        longint s;
        s = longint'(prev) * (64'sd65536 - longint'(w)) + longint'(cur) * longint'(w);
        return clip32((s + 64'sd32768) >>> 16);
    endfunction

    function automatic bit [63:0] sq_shift(input longint d);
        bit [63:0] m;
        m = (d < 0) ? -d : d;
        return (m * m) >> 16;
    endfunction

    // Rounds to nearest with ties away from zero.
    function automatic int stable_mean(input longint total, input int unsigned n);
        bit [63:0] m;
        bit [63:0] nn;
        longint    q;
        nn = n;
        m = (total < 0) ? -total : total;
        q = longint'((m + nn / 2) / nn);
        return clip32((total < 0) ? -q : q);
    endfunction

    function automatic void calibrate_and_filter(input t_sample_in it);
        t_accel_out  r;
        int          raw [3];
        int          ofs [3];
        int          acc [3];
        int unsigned w;
        int unsigned needed;
        bit [63:0]   dist_sum;
        acc = '{0, 0, 0};
        if (it.cmd == CMD_START) begin
            off_x = 0;
            off_y = 0;
            stable_total = '{0, 0};
            stable_n = 0;
            trial_n = 0;
            cal_phase = acsf_pkg::PH_RUN;
            want_reference = 1'b1;
        end else begin
            w = (cfg_wgt > 65536) ? 65536 : cfg_wgt;
            // The first two axes are swapped on the way in.
            raw[0] = flip16(it.w2);
            raw[1] = flip16(it.w1);
            raw[2] = flip16(it.w3);
            ofs = '{off_x, off_y, 0};
            for (int i = 0; i < 3; i++) begin
                acc[i] = clip32(longint'(raw[i]) * longint'(cfg_sens) - longint'(ofs[i]));
                smooth_v[i] = blend(smooth_v[i], acc[i], w);
            end
            if (cal_phase == acsf_pkg::PH_RUN) begin
                if (want_reference) begin
                    last_v = acc;
                    want_reference = 1'b0;
                end else begin
                    needed = (cfg_need == 0) ? 1 : cfg_need;
                    if (trial_n < 16'hFFFF) trial_n++;
                    dist_sum = '0;
                    for (int i = 0; i < 3; i++) begin
                        dist_sum += sq_shift(longint'(last_v[i]) - longint'(acc[i]));
                    end
                    if (dist_sum < 64'(cfg_thr)) begin
                        stable_total[0] += acc[0];
                        stable_total[1] += acc[1];
                        last_v = acc;
                        if (stable_n < 10'h3FF) stable_n++;
                    end
                    if (stable_n >= needed) begin
                        off_x = stable_mean(stable_total[0], stable_n);
                        off_y = stable_mean(stable_total[1], stable_n);
                        cal_phase = acsf_pkg::PH_DONE;
                    end else if (trial_n >= cfg_trial) begin
                        off_x = 0;
                        off_y = 0;
                        cal_phase = acsf_pkg::PH_FAIL;
                    end
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            r.accel[i] = acc[i];
            r.smooth[i] = smooth_v[i];
        end
        r.phase = cal_phase;
        accel_out_q.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] seen);
        if (seen !== want) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, seen);
            mismatches++;
        end
    endfunction

    // Input side: presents the oldest pending item and feeds the predictor on transfer.
    always @(posedge i_clk) begin : drive_inputs
        logic busy;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            busy = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                calibrate_and_filter(pending_samples.pop_front());
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_samples.size() != 0 && !src_hold &&
                    $urandom_range(99) >= src_idle_pct) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {pending_samples[0].w3, pending_samples[0].w2,
                                        pending_samples[0].w1};
                    i_s_axis_tuser  <= pending_samples[0].cmd;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: compares every result transfer with the oldest expectation.
    always @(posedge i_clk) begin : watch_outputs
        t_accel_out want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (accel_out_q.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    mismatches++;
                end else begin
                    want = accel_out_q.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        check_field($sformatf("accel_axis%0d", i), want.accel[i],
                                    o_m_axis_tdata[32*i +: 32]);
                        check_field($sformatf("smooth_axis%0d", i), want.smooth[i],
                                    o_m_axis_tdata[96 + 32*i +: 32]);
                    end
                    check_field("calib_phase", 32'(want.phase), 32'(o_m_axis_tdata[193:192]));
                    check_field("padding", '0, 32'(o_m_axis_tdata[199:194]));
                end
            end
            i_m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Long receiver hold-off, so that the block fills up and stalls its input.
    initial begin : long_stall
        wait (stall_request);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!i_rst_n) begin
            quiet = 0;
        end else if ((i_s_axis_tvalid && o_s_axis_tready) ||
                     (o_m_axis_tvalid && i_m_axis_tready) ||
                     (psel && penable && pready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input int unsigned val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= acsf_pkg::AddrW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            acsf_pkg::REG_SENS:  cfg_sens  = val & 32'hFFFF;
            acsf_pkg::REG_WGT:   cfg_wgt   = val & 32'h1FFFF;
            acsf_pkg::REG_THR:   cfg_thr   = val;
            acsf_pkg::REG_NEED:  cfg_need  = val & 32'h3FF;
            acsf_pkg::REG_TRIAL: cfg_trial = val & 32'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_calibration(input int unsigned sens, input int unsigned wgt,
                                   input int unsigned thr, input int unsigned need,
                                   input int unsigned trial);
        reg_write(acsf_pkg::REG_SENS, sens);
        reg_write(acsf_pkg::REG_WGT, wgt);
        reg_write(acsf_pkg::REG_THR, thr);
        reg_write(acsf_pkg::REG_NEED, need);
        reg_write(acsf_pkg::REG_TRIAL, trial);
    endtask

    function automatic void push_item(input logic cmd, input int a, input int b, input int c);
        t_sample_in it;
        it.cmd = cmd;
        it.w1 = a[15:0];
        it.w2 = b[15:0];
        it.w3 = c[15:0];
        pending_samples.push_back(it);
    endfunction

    function automatic int any_word();
        case ($urandom_range(7))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic int near_base(input int b);
        int v;
        v = b + int'($urandom_range(2 * scene_jit)) - scene_jit;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic void new_scene();
        for (int i = 0; i < 3; i++) begin
            scene_base[i] = any_word();
        end
        case ($urandom_range(5))
            0: scene_jit = 0;
            1: scene_jit = 1;
            2: scene_jit = 2;
            3: scene_jit = 4;
            4: scene_jit = 8;
            default: scene_jit = 64;
        endcase
    endfunction

    // Mostly calibration runs on a resting sensor, with restarts and bumps mixed in.
    function automatic void make_items(input int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 4) begin
                push_item(CMD_START, any_word(), any_word(), any_word());
                new_scene();
            end else if (r < 14) begin
                push_item(CMD_SAMPLE, any_word(), any_word(), any_word());
            end else begin
                push_item(CMD_SAMPLE, near_base(scene_base[0]), near_base(scene_base[1]),
                          near_base(scene_base[2]));
            end
        end
    endfunction

    task automatic drain();
        do @(posedge i_clk);
        while (pending_samples.size() != 0 || i_s_axis_tvalid || accel_out_q.size() != 0);
        // Let the block settle before the next register write.
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned sens, input int unsigned wgt,
                             input int unsigned thr, input int unsigned need,
                             input int unsigned trial, input int mode, input int press);
        set_calibration(sens, wgt, thr, need, trial);
        src_idle_pct   <= (mode == MODE_SRC) ? 74 : (mode == MODE_BOTH) ? 16 : 0;
        sink_stall_pct <= (mode == MODE_SINK) ? 74 : (mode == MODE_BOTH) ? 16 : 0;
        make_items(PHASE_ITEMS);
        if (press == PRESS_STALL) begin
            stall_request <= 1'b1;
        end else if (press == PRESS_PAUSE) begin
            do @(posedge i_clk);
            while (pending_samples.size() > PHASE_ITEMS / 2);
            src_hold <= 1'b1;
            do @(posedge i_clk);
            while (i_s_axis_tvalid || accel_out_q.size() != 0);
            src_hold <= 1'b0;
        end
        drain();
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Word extremes under the register reset values.
        push_item(CMD_SAMPLE, 0, 0, 0);
        push_item(CMD_SAMPLE, 32767, -32768, -1);
        push_item(CMD_SAMPLE, -32768, -32768, -32768);
        push_item(CMD_SAMPLE, -1, 1, 100);
        drain();

        set_calibration(65535, 32768, 32'hFFFF_FFFF, 3, 5);
        // A calibration that completes, with one outlier among the trials.
        push_item(CMD_START, 1234, -5678, 42);
        push_item(CMD_SAMPLE, 100, 200, 300);
        push_item(CMD_SAMPLE, -32768, 32767, 0);
        push_item(CMD_SAMPLE, 101, 201, 301);
        push_item(CMD_SAMPLE, 100, 199, 300);
        push_item(CMD_SAMPLE, 100, 200, 300);
        push_item(CMD_SAMPLE, 0, 0, 0);
        // Restarts: after the reference sample, and twice in a row.
        push_item(CMD_START, 0, 0, 0);
        push_item(CMD_SAMPLE, 5, 5, 5);
        push_item(CMD_START, 0, 0, 0);
        push_item(CMD_START, -1, -1, -1);
        // A calibration that runs out of trials.
        push_item(CMD_SAMPLE, 0, 0, 0);
        push_item(CMD_SAMPLE, 32767, 32767, 32767);
        push_item(CMD_SAMPLE, -32768, -32768, -32768);
        push_item(CMD_SAMPLE, 32767, -32768, 32767);
        push_item(CMD_SAMPLE, -32768, 32767, -32768);
        push_item(CMD_SAMPLE, 32767, 32767, -32768);
        push_item(CMD_SAMPLE, 7, -7, 7);
        drain();

        run_phase(0, 0, 0, 0, 0, MODE_NONE, PRESS_NONE);
        run_phase(65535, 131071, 32'hFFFF_FFFF, 1023, 65535, MODE_SRC, PRESS_NONE);
        run_phase(256, 65536, 164, 8, 40, MODE_SINK, PRESS_NONE);
        run_phase(1000, 20000, 5000, 20, 30, MODE_BOTH, PRESS_NONE);
        run_phase(4096, 70000, 100000, 4, 12, MODE_NONE, PRESS_STALL);
        run_phase(16, 1, 2, 1, 1, MODE_SRC, PRESS_PAUSE);
        run_phase(30000, 65535, 32'h0010_0000, 50, 200, MODE_SINK, PRESS_NONE);
        run_phase($urandom_range(65535), $urandom_range(65536), $urandom(),
                  $urandom_range(1, 30), $urandom_range(5, 100), MODE_BOTH, PRESS_NONE);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
